FILE: design/tdct_pkg.sv
// Package for the transmitter duty-cycle timer.
// Holds operation and command codes, field widths and the timer state type.
// No dependencies.
package tdct_pkg;

    localparam int unsigned SECS_W = 16;        // width of every seconds field
    localparam int unsigned SEC_CNT_W = SECS_W + 1;
    // Elapsed-seconds counter sticks here: at or above every 16-bit period
    localparam logic [SEC_CNT_W-1:0] SEC_CNT_MAX = {1'b1, {SECS_W{1'b0}}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BURST = 2'd1,
        OP_APPLY = 2'd2,
        OP_START = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ON_SECONDS  = 2'd0,
        REG_OFF_SECONDS = 2'd1
    } t_reg_idx;

    // Scheduler state apart from the tick counter
    typedef struct packed {
        logic              on_flag;
        logic [SECS_W-1:0] burst_length;
        logic [SECS_W-1:0] remaining;
    } t_tmr_state;

endpackage

FILE: design/tdct_core.sv
// Next-state logic of the transmitter duty-cycle timer for one input word.
// Depends on tdct_pkg. Purely combinational; the top level holds the registers.
module tdct_core
    import tdct_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 10,
    parameter int unsigned MAX_ON_SECONDS   = 1800,
    parameter int unsigned SUB_W            = 4
) (
    input  t_tmr_state           i_state,
    input  logic [SEC_CNT_W-1:0] i_sec,
    input  logic [SUB_W-1:0]     i_sub,
    input  t_op                  i_op,
    input  logic [SECS_W-1:0]    i_burst_seconds,
    input  logic [SECS_W-1:0]    i_on_seconds,
    input  logic [SECS_W-1:0]    i_off_seconds,
    output t_tmr_state           o_state,
    output logic [SEC_CNT_W-1:0] o_sec,
    output logic [SUB_W-1:0]     o_sub,
    output t_cmd                 o_cmd
);

    localparam logic [SUB_W-1:0]  SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);
    localparam logic [SECS_W-1:0] MAX_ON   = SECS_W'(MAX_ON_SECONDS);

    logic                 restart;
    logic                 burst_done;
    logic                 off_done;
    logic                 on_done;
    logic [SEC_CNT_W-1:0] base_sec;
    logic [SUB_W-1:0]     base_sub;

    // Period compares: ticks >= secs*TPS is the same as whole seconds >= secs
    assign burst_done = i_sec >= {1'b0, i_state.burst_length};
    assign off_done   = i_sec >= {1'b0, i_off_seconds};
    assign on_done    = i_sec >= {1'b0, i_on_seconds};

    always_comb begin
        o_state  = i_state;
        o_cmd    = CMD_NONE;
        restart  = 1'b0;
        o_sec    = i_sec;
        o_sub    = i_sub;
        base_sec = '0;
        base_sub = '0;

        unique case (i_op)
            OP_TICK: begin
                if (i_state.burst_length != '0) begin
                    if (burst_done) begin
                        o_cmd                = CMD_OFF;
                        o_state.on_flag      = 1'b0;
                        o_state.burst_length = '0;
                        o_state.remaining    = '0;
                        restart              = 1'b1;
                    end else begin
                        o_state.remaining = i_state.burst_length - i_sec[SECS_W-1:0];
                    end
                end else if (!i_state.on_flag) begin
                    if (off_done) begin
                        o_cmd           = CMD_ON;
                        o_state.on_flag = 1'b1;
                        restart         = 1'b1;
                    end
                end else begin
                    if (on_done) begin
                        o_cmd             = CMD_OFF;
                        o_state.on_flag   = 1'b0;
                        o_state.remaining = '0;
                        restart           = 1'b1;
                    end else begin
                        o_state.remaining = i_on_seconds - i_sec[SECS_W-1:0];
                    end
                end
                // Advance the counter, from zero after a switch; seconds stick at the cap
                base_sec = restart ? '0 : i_sec;
                base_sub = restart ? '0 : i_sub;
                if (base_sub == SUB_LAST) begin
                    o_sub = '0;
                    o_sec = (base_sec == SEC_CNT_MAX) ? SEC_CNT_MAX
                                                      : base_sec + SEC_CNT_W'(1);
                end else begin
                    o_sub = base_sub + SUB_W'(1);
                    o_sec = base_sec;
                end
            end
            OP_BURST: begin
                o_state.burst_length = i_burst_seconds;
                o_state.on_flag      = 1'b1;
                o_cmd                = CMD_ON;
                o_sec                = '0;
                o_sub                = '0;
            end
            OP_APPLY: begin
                if (i_on_seconds <= MAX_ON && i_off_seconds != '0) begin
                    o_state.on_flag = 1'b1;
                    o_cmd           = CMD_ON;
                    o_sec           = '0;
                    o_sub           = '0;
                end
            end
            OP_START: begin
                o_state.burst_length = '0;
                o_state.on_flag      = (i_on_seconds != '0);
                o_cmd                = (i_on_seconds != '0) ? CMD_ON : CMD_OFF;
                o_sec                = '0;
                o_sub                = '0;
            end
            default: begin
                o_cmd = CMD_NONE;
            end
        endcase
    end

endmodule

FILE: design/transmitter_duty_cycle_timer.sv
// Top level of the transmitter duty-cycle timer: handshakes, state registers,
// configuration registers and the result register. Depends on tdct_pkg, tdct_core.
//
// Usage:
//   Input words arrive on s_axis: tuser carries the operation (tick, start burst,
//   apply durations, start-up), tdata carries the burst length in seconds.
//   Each accepted word yields exactly one result word on m_axis with the
//   transmitter state, a transmit-on/off command and the seconds of on time left.
//   The user must write on/off periods via i_cfg_* only while idle; not enforced.
//   Latency: the result is valid in the cycle after the input word is accepted.
//   Throughput: one word per cycle while results are taken; all work is one
//   pass through the next-state logic between state and result registers.
//   The tick count is kept as whole seconds plus a tick-within-second counter,
//   so no divider is needed.
//   Stall: while a result waits and m_axis_tready is low, s_axis_tready is low;
//   the result register frees as it is taken, so a new word is accepted in the
//   same cycle.
//   Reset (synchronous, active low): transmitter off, counters, burst, remaining
//   and both periods cleared; no result pending.
module transmitter_duty_cycle_timer
    import tdct_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 10,
    parameter int unsigned MAX_ON_SECONDS   = 1800
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] burst_seconds
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] tx_on, [2:1] command,
                                        // [18:3] remaining_seconds, [23:19] zero
);

    localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

    t_tmr_state           r_state, n_state;
    logic [SEC_CNT_W-1:0] r_sec, n_sec;
    logic [SUB_W-1:0]     r_sub, n_sub;
    logic [SECS_W-1:0]    r_on_seconds;
    logic [SECS_W-1:0]    r_off_seconds;
    logic                 r_out_valid;
    logic                 r_out_tx_on;
    t_cmd                 r_out_cmd;
    logic [SECS_W-1:0]    r_out_remaining;
    t_cmd                 n_cmd;
    logic                 in_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Next state for the word on the input
    tdct_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .MAX_ON_SECONDS   (MAX_ON_SECONDS),
        .SUB_W            (SUB_W)
    ) u_core (
        .i_state         (r_state),
        .i_sec           (r_sec),
        .i_sub           (r_sub),
        .i_op            (t_op'(s_axis_tuser)),
        .i_burst_seconds (s_axis_tdata),
        .i_on_seconds    (r_on_seconds),
        .i_off_seconds   (r_off_seconds),
        .o_state         (n_state),
        .o_sec           (n_sec),
        .o_sub           (n_sub),
        .o_cmd           (n_cmd)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_seconds  <= '0;
            r_off_seconds <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ON_SECONDS:  r_on_seconds  <= i_cfg_wdata;
                REG_OFF_SECONDS: r_off_seconds <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Scheduler state: advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_sec   <= '0;
            r_sub   <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
            r_sec   <= n_sec;
            r_sub   <= n_sub;
        end
    end

    // Result register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_tx_on     <= n_state.on_flag;
            r_out_cmd       <= n_cmd;
            r_out_remaining <= n_state.remaining;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_remaining, r_out_cmd, r_out_tx_on};

    // Checks
    a_cmd_on_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == CMD_ON) |-> r_out_tx_on)
        else $error("transmit-on command with transmitter off");

    a_cmd_off_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == CMD_OFF) |-> !r_out_tx_on)
        else $error("transmit-off command with transmitter on");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub <= SUB_W'(TICKS_PER_SECOND - 1))
        else $error("tick-within-second counter out of range");

    a_sec_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= SEC_CNT_MAX)
        else $error("seconds counter passed its cap");

    a_switch_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_cmd != CMD_NONE && t_op'(s_axis_tuser) != OP_TICK)
        |=> (r_sec == '0 && r_sub == '0))
        else $error("counter not restarted on switch");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the transmitter duty-cycle timer.
// Drives stream words and period writes, predicts every result word in step.
// Depends on tdct_pkg and transmitter_duty_cycle_timer.
module testbench;
    import tdct_pkg::*;

    localparam int unsigned TICKS_PER_SEC  = 10;
    localparam int unsigned MAX_ON_SECS    = 1800;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Register index outside the defined set; writes to it must be ignored
    localparam logic [1:0]  REG_SPARE      = 2'd3;

    // Result word layout, highest bits first
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] remaining;
        t_cmd        command;
        logic        tx_on;
    } t_tx_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] burst_seconds
    logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [0] tx_on, [2:1] command, [18:3] remaining_seconds

    // Shadow of the scheduler state and the period registers
    logic        sh_on;
    logic [31:0] sh_ticks;
    logic [15:0] sh_burst;
    logic [15:0] sh_remain;
    logic [15:0] sh_on_secs;
    logic [15:0] sh_off_secs;

    t_tx_word    tx_results_due[$];
    bit          quiet;
    int unsigned sink_hold;
    int unsigned idle_cycles;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned reg_writes;
    int unsigned mismatches;
    int unsigned op_seen[4];
    int unsigned cmd_seen[4];

    transmitter_duty_cycle_timer #(
        .TICKS_PER_SECOND (TICKS_PER_SEC),
        .MAX_ON_SECONDS   (MAX_ON_SECS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Switch the transmitter and restart the tick count
    function automatic t_cmd switch_tx(logic on);
        sh_on = on;
        sh_ticks = '0;
        return on ? CMD_ON : CMD_OFF;
    endfunction

    // Advance the shadow state by one word and return the result it causes
    function automatic t_tx_word next_tx_result(t_op op, logic [15:0] secs);
        t_tx_word w;
        t_cmd cmd;
        longint unsigned ticks;
        ticks = longint'(sh_ticks);
        cmd = CMD_NONE;
        case (op)
            OP_TICK: begin
                if (sh_burst != 0) begin
                    if (ticks >= longint'(sh_burst) * TICKS_PER_SEC) begin
                        cmd = switch_tx(1'b0);
                        sh_burst = '0;
                        sh_remain = '0;
                    end else begin
                        sh_remain = 16'(longint'(sh_burst) - ticks / TICKS_PER_SEC);
                    end
                end else if (!sh_on) begin
                    if (ticks >= longint'(sh_off_secs) * TICKS_PER_SEC)
                        cmd = switch_tx(1'b1);
                end else begin
                    if (ticks >= longint'(sh_on_secs) * TICKS_PER_SEC) begin
                        cmd = switch_tx(1'b0);
                        sh_remain = '0;
                    end else begin
                        sh_remain = 16'(longint'(sh_on_secs) - ticks / TICKS_PER_SEC);
                    end
                end
                // saturate rather than wrap
                if (sh_ticks != '1)
                    sh_ticks = sh_ticks + 1;
            end
            OP_BURST: begin
                sh_burst = secs;
                cmd = switch_tx(1'b1);
            end
            OP_APPLY: begin
                if (sh_on_secs <= MAX_ON_SECS && sh_off_secs != 0)
                    cmd = switch_tx(1'b1);
            end
            default: begin
                sh_burst = '0;
                cmd = switch_tx(sh_on_secs != 0);
            end
        endcase
        w.pad = '0;
        w.remaining = sh_remain;
        w.command = cmd;
        w.tx_on = sh_on;
        return w;
    endfunction

    // Present one word, hold it until accepted, then record its result
    task automatic send_word(input t_op op, input logic [15:0] secs);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!s_axis_tready);
        tx_results_due.push_back(next_tx_result(op, secs));
        words_in++;
        op_seen[op]++;
    endtask

    // Drop valid and wait until every result word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tx_results_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            REG_ON_SECONDS:  sh_on_secs = val;
            REG_OFF_SECONDS: sh_off_secs = val;
            default: ;
        endcase
    endtask

    // Reprogram both periods while the block is idle
    task automatic program_periods(input logic [15:0] on_s, input logic [15:0] off_s,
                                   input bit with_spare);
        drain();
        if (with_spare)
            write_reg(REG_SPARE, 16'($urandom));
        write_reg(REG_ON_SECONDS, on_s);
        write_reg(REG_OFF_SECONDS, off_s);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(OP_TICK, 16'($urandom));
    endtask

    // Zero periods after reset: the transmitter flips on every tick
    task automatic test_zero_periods();
        send_ticks(3);
        drain();
    endtask

    // Burst expiry, a zero-second burst and the longest burst
    task automatic test_bursts();
        program_periods(16'd0, 16'd0, 1'b1);
        send_word(OP_BURST, 16'd1);
        send_ticks(11);
        send_word(OP_BURST, 16'd0);
        send_ticks(1);
        send_word(OP_BURST, 16'hFFFF);
        send_ticks(1);
        drain();
    endtask

    // Apply checks on the period limits, start-up with and without an on period
    task automatic test_apply_and_startup();
        program_periods(16'(MAX_ON_SECS + 1), 16'd5, 1'b0);
        send_word(OP_APPLY, 16'h0000);
        send_word(OP_START, 16'hFFFF);
        program_periods(16'(MAX_ON_SECS), 16'd0, 1'b0);
        send_word(OP_APPLY, 16'hA5A5);
        program_periods(16'(MAX_ON_SECS), 16'd1, 1'b0);
        send_word(OP_APPLY, 16'h5A5A);
        program_periods(16'd0, 16'd3, 1'b0);
        send_word(OP_START, 16'h0000);
        send_word(OP_APPLY, 16'h0000);
        drain();
    endtask

    // One random phase: mostly start-up or apply followed by a tick run,
    // bursts followed by a tick run that may outlast them, and some noise
    task automatic run_duty_phase(input logic [15:0] on_s, input logic [15:0] off_s,
                                  input int unsigned n_words, input bit calm);
        int unsigned stop_at;
        int unsigned r;
        int unsigned secs;
        program_periods(on_s, off_s, 1'b0);
        quiet = calm;
        stop_at = words_in + n_words;
        while (words_in < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_word($urandom_range(0, 1) ? OP_START : OP_APPLY, 16'($urandom));
                send_ticks($urandom_range(1, 120));
            end else if (r < 80) begin
                secs = $urandom_range(0, 4);
                send_word(OP_BURST, 16'(secs));
                send_ticks($urandom_range(1, secs * TICKS_PER_SEC + 12));
            end else if (r < 90) begin
                send_word(OP_BURST, 16'($urandom));
                send_ticks($urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(t_op'($urandom_range(0, 3)), 16'($urandom));
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    // Phase lengths are lower bounds; a phase may overrun by its last group of words
    task automatic test_random_duty();
        run_duty_phase(16'd0, 16'd0, 50, 1'b0);
        run_duty_phase(16'd1, 16'd1, 60, 1'b1);
        run_duty_phase(16'd2, 16'd1, 60, 1'b0);
        run_duty_phase(16'd1, 16'd3, 60, 1'b0);
        repeat (3)
            run_duty_phase(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), 60, 1'b0);
        run_duty_phase(16'(MAX_ON_SECS), 16'd1, 60, 1'b1);
        run_duty_phase(16'(MAX_ON_SECS + 1), 16'd1, 50, 1'b0);
        run_duty_phase(16'hFFFF, 16'hFFFF, 50, 1'b0);
        run_duty_phase(16'($urandom), 16'($urandom), 50, 1'b1);
        run_duty_phase(16'd3, 16'd0, 60, 1'b0);
        run_duty_phase(16'd0, 16'd2, 60, 1'b0);
    endtask

    // Result side: random back-pressure
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold <= pick_gap();
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_tx_word got;
        t_tx_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (tx_results_due.size() == 0) begin
                $error("result word %h with nothing expected", m_axis_tdata);
                mismatches++;
            end else begin
                want = tx_results_due.pop_front();
                words_out++;
                cmd_seen[got.command]++;
                if (got.tx_on !== want.tx_on) begin
                    $error("tx_on: expected %0d, got %0d", want.tx_on, got.tx_on);
                    mismatches++;
                end
                if (got.command !== want.command) begin
                    $error("command: expected %0d, got %0d", want.command, got.command);
                    mismatches++;
                end
                if (got.remaining !== want.remaining) begin
                    $error("remaining_seconds: expected %0d, got %0d",
                           want.remaining, got.remaining);
                    mismatches++;
                end
                if (got.pad !== want.pad) begin
                    $error("pad: expected %0d, got %0d", want.pad, got.pad);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run: too long without any word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("transmitter_duty_cycle_timer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sh_on = 1'b0;
        sh_ticks = '0;
        sh_burst = '0;
        sh_remain = '0;
        sh_on_secs = '0;
        sh_off_secs = '0;
        quiet = 1'b0;
        sink_hold = 0;
        idle_cycles = 0;
        words_in = 0;
        words_out = 0;
        reg_writes = 0;
        mismatches = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_periods();
        test_bursts();
        test_apply_and_startup();
        test_random_duty();

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d words (%0d tick, %0d burst, %0d apply, %0d start-up), %0d period writes.",
                 words_in, op_seen[OP_TICK], op_seen[OP_BURST], op_seen[OP_APPLY],
                 op_seen[OP_START], reg_writes);
        $display("Checked %0d result words: %0d on and %0d off commands, %0d errors.",
                 words_out, cmd_seen[CMD_ON], cmd_seen[CMD_OFF], mismatches);
        if (mismatches == 0) begin
            $display("transmitter_duty_cycle_timer: match");
        end else begin
            $display("transmitter_duty_cycle_timer: mismatch");
        end
        $finish;
    end

endmodule

FILE: transmitter_duty_cycle_timer.f
design/tdct_pkg.sv
design/tdct_core.sv
design/transmitter_duty_cycle_timer.sv
tb/testbench.sv
